// ===== src/nfa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nfa_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned NODE_COUNT_DEF = 64;
  localparam int unsigned LABEL_BITS_DEF = 7;

  // fixed field widths of the ports
  localparam int unsigned NODE_W     = 6;
  localparam int unsigned FIELD_LW   = 7;
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 6;

  // input beat actions
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FEED  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_END   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY  = 2'd2;

  // what the edge unit looks for
  typedef enum logic {
    MODE_CLOSE,
    MODE_FEED
  } mode_e;

  // command from the port side to the sequencer
  typedef struct packed {
    logic                go;
    logic [ACTION_W-1:0] action;
    logic                room;
  } cmd_t;

  // status from the sequencer back to the port side
  typedef struct packed {
    logic idle;
    logic res_valid;
    logic matched;
  } status_t;

endpackage

`default_nettype wire

// ===== src/nfa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfa_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/nfa_edge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfa_edge #(
  parameter int unsigned NODE_COUNT = nfa_pkg::NODE_COUNT_DEF,
  parameter int unsigned LABEL_BITS = nfa_pkg::LABEL_BITS_DEF
) (
  input  wire logic [2*(LABEL_BITS+nfa_pkg::NODE_W)-1:0] entry_i,
  input  wire nfa_pkg::mode_e                            mode_i,
  input  wire logic [LABEL_BITS-1:0]                     symbol_i,
  output logic      [1:0]                                hit_o,
  output logic      [1:0][$clog2(NODE_COUNT)-1:0]        tgt_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned HW = LABEL_BITS + nfa_pkg::NODE_W;
  localparam int unsigned CW = ((AW > nfa_pkg::NODE_W) ? AW : nfa_pkg::NODE_W) + 1;
  localparam logic [LABEL_BITS-1:0] EPS = {LABEL_BITS{1'b1}};

  logic sym_ok;

  // symbol zero and the epsilon code never match a labelled edge
  assign sym_ok = (symbol_i != '0) && (symbol_i != EPS);

  // both transitions of one entry, first one in the upper half
  always_comb begin
    logic [LABEL_BITS-1:0]     label;
    logic [nfa_pkg::NODE_W-1:0] tgt;
    logic                      lab_hit;
    for (int e = 0; e < 2; e++) begin
      {label, tgt} = entry_i[(1-e)*HW +: HW];
      if (mode_i == nfa_pkg::MODE_CLOSE) begin
        lab_hit = (label == EPS);
      end else begin
        lab_hit = sym_ok && (label == symbol_i);
      end
      hit_o[e] = lab_hit && (CW'(tgt) < CW'(NODE_COUNT));
      tgt_o[e] = AW'(tgt);
    end
  end

endmodule

`default_nettype wire

// ===== src/nfa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module nfa_ctrl #(
  parameter int unsigned NODE_COUNT = nfa_pkg::NODE_COUNT_DEF,
  parameter int unsigned LABEL_BITS = nfa_pkg::LABEL_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire nfa_pkg::cmd_t              cmd_i,
  input  wire logic [nfa_pkg::NODE_W-1:0] node_index_i,
  input  wire logic [LABEL_BITS-1:0]      first_label_i,
  input  wire logic [nfa_pkg::NODE_W-1:0] first_target_i,
  input  wire logic [LABEL_BITS-1:0]      second_label_i,
  input  wire logic [nfa_pkg::NODE_W-1:0] second_target_i,
  input  wire logic [LABEL_BITS-1:0]      symbol_i,
  input  wire logic [nfa_pkg::NODE_W-1:0] start_node_i,
  input  wire logic [nfa_pkg::NODE_W-1:0] accept_node_i,
  input  wire logic                       empty_pattern_i,
  output nfa_pkg::status_t                status_o
);

  localparam int unsigned AW = $clog2(NODE_COUNT);
  localparam int unsigned SW = $clog2(NODE_COUNT + 1);
  localparam int unsigned EW = 2 * (LABEL_BITS + nfa_pkg::NODE_W);
  localparam int unsigned CW = ((AW > nfa_pkg::NODE_W) ? AW : nfa_pkg::NODE_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_REPORT
  } state_e;

  typedef enum logic [1:0] {
    NX_IDLE,
    NX_FEED,
    NX_REPORT
  } then_e;

  state_e                  state_q, state_d;
  then_e                   then_q, then_d;
  nfa_pkg::mode_e          mode_q, mode_d;
  logic [SW-1:0]           scan_q, scan_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [AW-1:0]           rd_node_q, rd_node_d;
  logic                    changed_q, changed_d;
  logic                    seen_q, seen_d;
  logic [LABEL_BITS-1:0]   sym_q, sym_d;
  logic [NODE_COUNT-1:0]   active_q, active_d;
  logic [NODE_COUNT-1:0]   next_q, next_d;
  logic                    res_q, res_d;
  logic                    matched_q, matched_d;

  logic                    ram_we;
  logic [EW-1:0]           ram_wdata;
  logic [EW-1:0]           ram_rdata;
  logic                    issue;
  logic                    wr_ok;
  logic                    start_ok;
  logic                    accept_ok;
  logic [1:0]              hit;
  logic [1:0][AW-1:0]      tgt;

  // range checks on node numbers
  assign wr_ok     = CW'(node_index_i) < CW'(NODE_COUNT);
  assign start_ok  = CW'(start_node_i) < CW'(NODE_COUNT);
  assign accept_ok = CW'(accept_node_i) < CW'(NODE_COUNT);
  assign issue     = scan_q < SW'(NODE_COUNT);

  assign ram_wdata = {first_label_i, first_target_i, second_label_i, second_target_i};

  // node table
  nfa_ram #(
    .WIDTH (EW),
    .DEPTH (NODE_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(node_index_i)),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // shared transition matcher
  nfa_edge #(
    .NODE_COUNT (NODE_COUNT),
    .LABEL_BITS (LABEL_BITS)
  ) u_edge (
    .entry_i  (ram_rdata),
    .mode_i   (mode_q),
    .symbol_i (sym_q),
    .hit_o    (hit),
    .tgt_o    (tgt)
  );

  // sequencer: load start, scan passes, report
  always_comb begin
    state_d   = state_q;
    then_d    = then_q;
    mode_d    = mode_q;
    scan_d    = scan_q;
    rd_vld_d  = 1'b0;
    rd_node_d = scan_q[AW-1:0];
    changed_d = changed_q;
    seen_d    = seen_q;
    sym_d     = sym_q;
    active_d  = active_q;
    next_d    = next_q;
    res_d     = 1'b0;
    matched_d = matched_q;
    ram_we    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          unique case (cmd_i.action)
            nfa_pkg::ACT_WRITE: begin
              ram_we = wr_ok;
            end
            nfa_pkg::ACT_FEED: begin
              sym_d  = symbol_i;
              seen_d = 1'b1;
              if (seen_q) begin
                state_d = S_SCAN;
                mode_d  = nfa_pkg::MODE_FEED;
                scan_d  = '0;
                next_d  = '0;
              end else begin
                state_d = S_LOAD;
                then_d  = NX_FEED;
              end
            end
            nfa_pkg::ACT_END: begin
              if (seen_q) begin
                state_d = S_REPORT;
              end else begin
                state_d = S_LOAD;
                then_d  = NX_REPORT;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOAD: begin
        active_d = '0;
        if (start_ok) begin
          active_d[AW'(start_node_i)] = 1'b1;
        end
        state_d   = S_SCAN;
        mode_d    = nfa_pkg::MODE_CLOSE;
        scan_d    = '0;
        changed_d = 1'b0;
      end
      S_SCAN: begin
        // issue one table read per cycle
        if (issue) begin
          scan_d   = scan_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        // apply the entry read last cycle if its node is active
        if (rd_vld_q && active_q[rd_node_q]) begin
          for (int e = 0; e < 2; e++) begin
            if (hit[e]) begin
              if (mode_q == nfa_pkg::MODE_FEED) begin
                next_d[tgt[e]] = 1'b1;
              end else begin
                if (!active_q[tgt[e]]) begin
                  changed_d = 1'b1;
                end
                active_d[tgt[e]] = 1'b1;
              end
            end
          end
        end
        // pass finished
        if (!issue && !rd_vld_q) begin
          scan_d    = '0;
          changed_d = 1'b0;
          if (mode_q == nfa_pkg::MODE_FEED) begin
            active_d = next_q;
            mode_d   = nfa_pkg::MODE_CLOSE;
            then_d   = NX_IDLE;
          end else if (!changed_q) begin
            unique case (then_q)
              NX_FEED: begin
                mode_d = nfa_pkg::MODE_FEED;
                next_d = '0;
              end
              NX_REPORT: state_d = S_REPORT;
              NX_IDLE:   state_d = S_IDLE;
            endcase
          end
        end
      end
      S_REPORT: begin
        if (cmd_i.room) begin
          res_d     = 1'b1;
          matched_d = empty_pattern_i ? !seen_q
                                      : (accept_ok && active_q[AW'(accept_node_i)]);
          seen_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      then_q    <= NX_IDLE;
      mode_q    <= nfa_pkg::MODE_CLOSE;
      scan_q    <= '0;
      rd_vld_q  <= 1'b0;
      rd_node_q <= '0;
      changed_q <= 1'b0;
      seen_q    <= 1'b0;
      sym_q     <= '0;
      active_q  <= '0;
      next_q    <= '0;
      res_q     <= 1'b0;
      matched_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      then_q    <= then_d;
      mode_q    <= mode_d;
      scan_q    <= scan_d;
      rd_vld_q  <= rd_vld_d;
      rd_node_q <= rd_node_d;
      changed_q <= changed_d;
      seen_q    <= seen_d;
      sym_q     <= sym_d;
      active_q  <= active_d;
      next_q    <= next_d;
      res_q     <= res_d;
      matched_q <= matched_d;
    end
  end

  assign status_o.idle      = (state_q == S_IDLE);
  assign status_o.res_valid = res_q;
  assign status_o.matched   = matched_q;

  // checks
  a_cmd_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go |-> state_q == S_IDLE)
    else $error("command beat taken while sequencer busy");

  a_rd_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_SCAN)
    else $error("table read data pending outside a scan");

  a_res_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q |-> $past(state_q == S_REPORT) && state_q == S_IDLE)
    else $error("result without a report step");

endmodule

`default_nettype wire

// ===== src/nfa_sequence_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// NFA sequence matcher
// Input channel (in_valid_i / in_ready_o) carries one beat per action: write
// a node entry, feed a symbol, or end the sequence. Only an end beat yields a
// result beat on the output channel (out_valid_o / out_ready_i, matched_o).
// Configuration (start node, accept node, empty-pattern mode) is written
// through cfg_we_i / cfg_index_i / cfg_data_i; the user must write it only
// while the block is idle, which the block itself does not enforce.
// One beat is processed at a time; in_ready_o is low while it is at work.
// A feed takes one table scan for the symbol step plus one scan per
// epsilon-closure pass (at most longest epsilon chain + 1 passes); the first
// symbol of a sequence adds a load step and the closure passes of the start
// node. An end beat goes to the report step, after the start closure when no
// symbol was fed. The single table read port sets the rate: one node entry per cycle.
// After reset the configuration is zero, no symbol has been seen and the
// node table holds nothing defined until written. When the receiver stalls,
// the result waits in the output register and the next end beat waits for it.
module nfa_sequence_matcher #(
  parameter int unsigned NODE_COUNT = nfa_pkg::NODE_COUNT_DEF,
  parameter int unsigned LABEL_BITS = nfa_pkg::LABEL_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [nfa_pkg::ACTION_W-1:0]   action_i,
  input  wire logic [nfa_pkg::NODE_W-1:0]     node_index_i,
  input  wire logic [nfa_pkg::FIELD_LW-1:0]   first_label_i,
  input  wire logic [nfa_pkg::NODE_W-1:0]     first_target_i,
  input  wire logic [nfa_pkg::FIELD_LW-1:0]   second_label_i,
  input  wire logic [nfa_pkg::NODE_W-1:0]     second_target_i,
  input  wire logic [nfa_pkg::FIELD_LW-1:0]   symbol_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                matched_o
);

  logic [nfa_pkg::NODE_W-1:0] start_q;
  logic [nfa_pkg::NODE_W-1:0] accept_q;
  logic                       empty_q;
  logic                       out_valid_q;
  logic                       out_matched_q;
  nfa_pkg::cmd_t              cmd;
  nfa_pkg::status_t           sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      accept_q <= '0;
      empty_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        nfa_pkg::CFG_START:  start_q  <= cfg_data_i;
        nfa_pkg::CFG_ACCEPT: accept_q <= cfg_data_i;
        nfa_pkg::CFG_EMPTY:  empty_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_ready_o = sts.idle;
  assign cmd.go     = in_valid_i && sts.idle;
  assign cmd.action = action_i;
  assign cmd.room   = !out_valid_q;

  nfa_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .LABEL_BITS (LABEL_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .node_index_i    (node_index_i),
    .first_label_i   (LABEL_BITS'(first_label_i)),
    .first_target_i  (first_target_i),
    .second_label_i  (LABEL_BITS'(second_label_i)),
    .second_target_i (second_target_i),
    .symbol_i        (LABEL_BITS'(symbol_i)),
    .start_node_i    (start_q),
    .accept_node_i   (accept_q),
    .empty_pattern_i (empty_q),
    .status_o        (sts)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      out_matched_q <= 1'b0;
    end else if (sts.res_valid) begin
      out_valid_q   <= 1'b1;
      out_matched_q <= sts.matched;
    end else if (out_ready_i) begin
      out_valid_q   <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = out_matched_q;

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.res_valid |-> !out_valid_q)
    else $error("result beat would overwrite a pending one");

endmodule

`default_nettype wire

// ===== tb/nfa_match_checker.sv =====
`timescale 1ns / 1ps

module nfa_match_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [nfa_pkg::ACTION_W-1:0]   action_i,
  input  logic [nfa_pkg::NODE_W-1:0]     node_index_i,
  input  logic [nfa_pkg::FIELD_LW-1:0]   first_label_i,
  input  logic [nfa_pkg::NODE_W-1:0]     first_target_i,
  input  logic [nfa_pkg::FIELD_LW-1:0]   second_label_i,
  input  logic [nfa_pkg::NODE_W-1:0]     second_target_i,
  input  logic [nfa_pkg::FIELD_LW-1:0]   symbol_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           matched_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    outstanding_o
);
  import nfa_pkg::*;

  localparam int unsigned         NODES     = NODE_COUNT_DEF;
  localparam logic [FIELD_LW-1:0] EPS_LABEL = '1;
  localparam logic [FIELD_LW-1:0] NO_ARC    = '0;

  // one node entry: two labelled arcs
  typedef struct packed {
    logic [FIELD_LW-1:0] lbl_a;
    logic [NODE_W-1:0]   tgt_a;
    logic [FIELD_LW-1:0] lbl_b;
    logic [NODE_W-1:0]   tgt_b;
  } arc_pair_t;

  arc_pair_t         arcs [NODES];
  logic [NODES-1:0]  live_nodes;
  logic              seen_symbol;
  logic [NODE_W-1:0] root_node;
  logic [NODE_W-1:0] goal_node;
  logic              empty_mode;
  logic              pending_matches [$];

  task automatic report_miss(input string what);
    $display("%0t checker: %s", $time, what);
    mismatch_count_o++;
  endtask

  // grow a node set along epsilon arcs until nothing new turns up
  function automatic logic [NODES-1:0] close_over_eps(input logic [NODES-1:0] seed);
    logic [NODES-1:0] acc;
    logic             grew;
    acc  = seed;
    grew = 1'b1;
    while (grew) begin
      grew = 1'b0;
      for (int n = 0; n < NODES; n++) begin
        if (acc[n]) begin
          if (arcs[n].lbl_a == EPS_LABEL && !acc[arcs[n].tgt_a]) begin
            acc[arcs[n].tgt_a] = 1'b1;
            grew = 1'b1;
          end
          if (arcs[n].lbl_b == EPS_LABEL && !acc[arcs[n].tgt_b]) begin
            acc[arcs[n].tgt_b] = 1'b1;
            grew = 1'b1;
          end
        end
      end
    end
    return acc;
  endfunction

  function automatic logic [NODES-1:0] root_closure();
    logic [NODES-1:0] seed;
    seed            = '0;
    seed[root_node] = 1'b1;
    return close_over_eps(seed);
  endfunction

  // one symbol step; zero and the epsilon code match no arc
  function automatic logic [NODES-1:0] advance_on(input logic [NODES-1:0] cur,
                                                  input logic [FIELD_LW-1:0] sym);
    logic [NODES-1:0] nxt;
    nxt = '0;
    if (sym != NO_ARC && sym != EPS_LABEL) begin
      for (int n = 0; n < NODES; n++) begin
        if (cur[n]) begin
          if (arcs[n].lbl_a == sym) nxt[arcs[n].tgt_a] = 1'b1;
          if (arcs[n].lbl_b == sym) nxt[arcs[n].tgt_b] = 1'b1;
        end
      end
    end
    return close_over_eps(nxt);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      for (int n = 0; n < NODES; n++) arcs[n] = '0;
      live_nodes  = '0;
      seen_symbol = 1'b0;
      root_node   = '0;
      goal_node   = '0;
      empty_mode  = 1'b0;
      pending_matches.delete();
      mismatch_count_o = 0;
    end else begin
      // result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (pending_matches.size() == 0) begin
          report_miss($sformatf("result beat matched=%b with nothing expected", matched_i));
        end else begin
          want = pending_matches.pop_front();
          if (matched_i !== want)
            report_miss($sformatf("matched=%b, expected %b", matched_i, want));
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START:  root_node  = cfg_data_i[NODE_W-1:0];
          CFG_ACCEPT: goal_node  = cfg_data_i[NODE_W-1:0];
          CFG_EMPTY:  empty_mode = cfg_data_i[0];
          default: ;
        endcase
      end

      // input beat
      if (in_valid_i && in_ready_i) begin
        case (action_i)
          ACT_WRITE: begin
            arcs[node_index_i] = '{first_label_i, first_target_i,
                                   second_label_i, second_target_i};
          end
          ACT_FEED: begin
            if (!seen_symbol) live_nodes = root_closure();
            live_nodes  = advance_on(live_nodes, symbol_i);
            seen_symbol = 1'b1;
          end
          ACT_END: begin
            if (!seen_symbol) live_nodes = root_closure();
            if (empty_mode) want = !seen_symbol;
            else want = live_nodes[goal_node];
            pending_matches.push_back(want);
            seen_symbol = 1'b0;
            live_nodes  = root_closure();
          end
          default: ;
        endcase
      end
    end
    outstanding_o = pending_matches.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import nfa_pkg::*;

  localparam int unsigned         NODES         = NODE_COUNT_DEF;
  localparam logic [FIELD_LW-1:0] EPS_LABEL     = '1;
  localparam logic [FIELD_LW-1:0] NO_ARC        = '0;
  localparam logic [ACTION_W-1:0] ACT_SPARE     = 2'd3;
  localparam int unsigned         ITEM_GOAL     = 450;
  localparam int unsigned         SETTLE_CYCLES = (NODES + 1) * (NODES + 2);

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [ACTION_W-1:0]   action_i;
  logic [NODE_W-1:0]     node_index_i;
  logic [FIELD_LW-1:0]   first_label_i;
  logic [NODE_W-1:0]     first_target_i;
  logic [FIELD_LW-1:0]   second_label_i;
  logic [NODE_W-1:0]     second_target_i;
  logic [FIELD_LW-1:0]   symbol_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  matched_o;

  int unsigned mismatches;
  int unsigned outstanding;

  // stimulus state: alphabet and node set of the current phase
  int unsigned         burst_left;
  int unsigned         items_sent;
  logic [FIELD_LW-1:0] alpha [6];
  int unsigned         alpha_n;
  logic [NODE_W-1:0]   hot [NODES];
  int unsigned         hot_n;

  nfa_sequence_matcher dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .action_i        (action_i),
    .node_index_i    (node_index_i),
    .first_label_i   (first_label_i),
    .first_target_i  (first_target_i),
    .second_label_i  (second_label_i),
    .second_target_i (second_target_i),
    .symbol_i        (symbol_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .matched_o       (matched_o)
  );

  nfa_match_checker watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .action_i         (action_i),
    .node_index_i     (node_index_i),
    .first_label_i    (first_label_i),
    .first_target_i   (first_target_i),
    .second_label_i   (second_label_i),
    .second_target_i  (second_target_i),
    .symbol_i         (symbol_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .matched_i        (matched_o),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  initial begin
    #200_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver stalls, switching style every so often
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    logic [15:0] pattern;
    out_ready_i = 1'b0;
    mode        = RX_OPEN;
    left        = 0;
    pattern     = '1;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        left    = $urandom_range(16, 160);
        pattern = 16'($urandom());
      end
      left--;
      case (mode)
        RX_OPEN:   out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready_i <= ($urandom_range(0, 7) == 0);
        default: begin
          out_ready_i <= pattern[0];
          pattern = {pattern[0], pattern[15:1]};
        end
      endcase
    end
  end

  // one input beat, with bursts and gaps on the sender side
  task automatic drive_beat(input logic [ACTION_W-1:0] act, input logic [NODE_W-1:0] idx,
                            input logic [FIELD_LW-1:0] l1, input logic [NODE_W-1:0] t1,
                            input logic [FIELD_LW-1:0] l2, input logic [NODE_W-1:0] t2,
                            input logic [FIELD_LW-1:0] sym);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    action_i        <= act;
    node_index_i    <= idx;
    first_label_i   <= l1;
    first_target_i  <= t1;
    second_label_i  <= l2;
    second_target_i <= t2;
    symbol_i        <= sym;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (act != ACT_SPARE) items_sent++;
    @(negedge clk_i);
  endtask

  // beat whose unused fields carry random junk
  task automatic rand_beat(input logic [ACTION_W-1:0] act, input logic [FIELD_LW-1:0] sym);
    drive_beat(act, NODE_W'($urandom()), FIELD_LW'($urandom()), NODE_W'($urandom()),
               FIELD_LW'($urandom()), NODE_W'($urandom()), sym);
  endtask

  task automatic write_node(input logic [NODE_W-1:0] idx,
                            input logic [FIELD_LW-1:0] l1, input logic [NODE_W-1:0] t1,
                            input logic [FIELD_LW-1:0] l2, input logic [NODE_W-1:0] t2);
    drive_beat(ACT_WRITE, idx, l1, t1, l2, t2, FIELD_LW'($urandom()));
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic quiesce(input int unsigned extra);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [NODE_W-1:0] root, input logic [NODE_W-1:0] goal,
                          input logic empty);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START;
    cfg_data_i  <= root;
    @(negedge clk_i);
    cfg_index_i <= CFG_ACCEPT;
    cfg_data_i  <= goal;
    @(negedge clk_i);
    cfg_index_i <= CFG_EMPTY;
    cfg_data_i  <= CFG_DATA_W'(empty);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // labels lean on the phase alphabet and on epsilon arcs
  function automatic logic [FIELD_LW-1:0] pick_label();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return EPS_LABEL;
    if (r < 35) return NO_ARC;
    if (r < 90) return alpha[$urandom_range(0, alpha_n - 1)];
    return FIELD_LW'($urandom_range(1, 126));
  endfunction

  function automatic logic [NODE_W-1:0] pick_target();
    if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, 63));
    return hot[$urandom_range(0, hot_n - 1)];
  endfunction

  function automatic logic [FIELD_LW-1:0] pick_symbol();
    if ($urandom_range(0, 9) == 0) return FIELD_LW'($urandom_range(1, 126));
    return alpha[$urandom_range(0, alpha_n - 1)];
  endfunction

  // one random phase: fresh registers, a rewired node set, then sequences
  task automatic run_phase();
    int unsigned n_seq;
    int unsigned len;
    int unsigned r;
    alpha_n = $urandom_range(1, 5);
    for (int i = 0; i < alpha_n; i++)
      alpha[i] = $urandom_range(0, 1) ? FIELD_LW'($urandom_range(1, 8))
                                      : FIELD_LW'($urandom_range(1, 126));
    hot_n = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 64) : $urandom_range(3, 12);
    for (int i = 0; i < hot_n; i++) hot[i] = NODE_W'($urandom_range(0, 63));
    quiesce(SETTLE_CYCLES);
    set_regs(hot[$urandom_range(0, hot_n - 1)], hot[$urandom_range(0, hot_n - 1)],
             $urandom_range(0, 4) == 0);
    for (int i = 0; i < hot_n; i++)
      write_node(hot[i], pick_label(), pick_target(), pick_label(), pick_target());
    n_seq = $urandom_range(2, 7);
    repeat (n_seq) begin
      len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 6)
          write_node(hot[$urandom_range(0, hot_n - 1)], pick_label(), pick_target(),
                     pick_label(), pick_target());
        else if (r < 9)
          rand_beat(ACT_SPARE, FIELD_LW'($urandom()));
        else
          rand_beat(ACT_FEED, pick_symbol());
      end
      if ($urandom_range(0, 7) == 0) quiesce(0);
      rand_beat(ACT_END, FIELD_LW'($urandom()));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    action_i        = '0;
    node_index_i    = '0;
    first_label_i   = '0;
    first_target_i  = '0;
    second_label_i  = '0;
    second_target_i = '0;
    symbol_i        = '0;
    burst_left      = 0;
    items_sent      = 0;
    alpha_n         = 1;
    hot_n           = 1;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // whole table loaded: a small hand-built automaton, other nodes without arcs
    set_regs(6'd0, 6'd63, 1'b0);
    for (int i = 0; i < NODES; i++) begin
      case (i)
        0:       write_node(6'd0, EPS_LABEL, 6'd1, 7'd5, 6'd2);
        1:       write_node(6'd1, 7'd126, 6'd63, NO_ARC, 6'd0);
        2:       write_node(6'd2, EPS_LABEL, 6'd63, 7'd1, 6'd0);
        NODES-1: write_node(6'd63, NO_ARC, 6'd0, EPS_LABEL, 6'd63);
        default: write_node(NODE_W'(i), NO_ARC, 6'd0, NO_ARC, 6'd0);
      endcase
    end

    // no symbol: only the start closure
    rand_beat(ACT_END, 7'd0);
    // straight to the accept node
    rand_beat(ACT_FEED, 7'd126);
    rand_beat(ACT_END, 7'd0);
    // out over an epsilon arc and back to the root
    rand_beat(ACT_FEED, 7'd5);
    rand_beat(ACT_FEED, 7'd1);
    rand_beat(ACT_END, 7'd0);
    rand_beat(ACT_FEED, 7'd5);
    rand_beat(ACT_END, 7'd0);
    // symbol zero and the epsilon code empty the active set
    rand_beat(ACT_FEED, NO_ARC);
    rand_beat(ACT_END, 7'd0);
    rand_beat(ACT_FEED, EPS_LABEL);
    rand_beat(ACT_END, 7'd0);
    // unknown action is dropped
    rand_beat(ACT_SPARE, 7'd126);
    // table change before the first symbol reaches the start closure
    write_node(6'd1, EPS_LABEL, 6'd63, NO_ARC, 6'd0);
    rand_beat(ACT_END, 7'd0);
    write_node(6'd1, 7'd126, 6'd63, NO_ARC, 6'd0);
    // table change mid-sequence only affects later symbols
    rand_beat(ACT_FEED, 7'd5);
    write_node(6'd2, 7'd1, 6'd63, NO_ARC, 6'd0);
    rand_beat(ACT_FEED, 7'd1);
    rand_beat(ACT_END, 7'd0);
    // empty-pattern mode
    quiesce(SETTLE_CYCLES);
    set_regs(6'd0, 6'd63, 1'b1);
    rand_beat(ACT_END, 7'd0);
    rand_beat(ACT_FEED, 7'd126);
    rand_beat(ACT_END, 7'd0);
    // root at the top node, accepting on itself
    quiesce(SETTLE_CYCLES);
    set_regs(6'd63, 6'd63, 1'b0);
    rand_beat(ACT_END, 7'd0);
    rand_beat(ACT_FEED, 7'd126);
    rand_beat(ACT_END, 7'd0);

    // random phases
    while (items_sent < ITEM_GOAL) run_phase();

    quiesce(SETTLE_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
